>>> design/sorted_group_by_aggregator_macros.svh
// assertion macros for the sorted group-by aggregator checker
// needs clk_i and rst_ni in the scope where a macro is used
`ifndef SORTED_GROUP_BY_AGGREGATOR_MACROS_SVH
`define SORTED_GROUP_BY_AGGREGATOR_MACROS_SVH

// checked at every edge outside reset
`define SGA_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("sga check failed");

// checked at every edge, reset included
`define SGA_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) (prop)) \
    else $error("sga reset check failed");

`endif

>>> design/sga_pkg.sv
// shared types and constants of the sorted group-by aggregator
// no dependencies
`default_nettype none

package sga_pkg;

  localparam int unsigned DataW    = 32;
  localparam int unsigned NumCols  = 4;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 3;
  localparam int unsigned SrcW     = 2;
  localparam int unsigned DivSteps = 32;
  localparam int unsigned DivCntW  = 5;

  // register indexes: functions first, then column selects
  localparam logic [CfgIdxW-1:0] CfgFuncA = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgSrcA  = 3'd4;

  typedef enum logic [2:0] {
    FN_SUM   = 3'd0,
    FN_COUNT = 3'd1,
    FN_MIN   = 3'd2,
    FN_MAX   = 3'd3,
    FN_AVG   = 3'd4
  } func_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_APPLY,
    ST_EMIT,
    ST_DIV,
    ST_PUSH
  } state_e;

  typedef struct packed {
    logic signed [DataW-1:0] row_key;
    logic signed [DataW-1:0] col_a;
    logic signed [DataW-1:0] col_b;
    logic signed [DataW-1:0] col_c;
    logic signed [DataW-1:0] col_d;
    logic                    final_row;
  } in_t;

  typedef struct packed {
    logic signed [DataW-1:0] group_key;
    logic signed [DataW-1:0] agg_a;
    logic signed [DataW-1:0] agg_b;
    logic signed [DataW-1:0] agg_c;
    logic signed [DataW-1:0] agg_d;
    logic                    run_end;
  } out_t;

  typedef struct packed {
    logic apply;
    logic first;
    logic start;
    logic step;
  } lane_ctl_t;

  typedef logic [NumCols-1:0][DataW-1:0] cols_t;

endpackage

`default_nettype wire

>>> design/sga_div.sv
// serial restoring divider, one quotient bit per step
// signed dividend over an unsigned nonzero divisor, truncating toward zero; uses sga_pkg
`default_nettype none

module sga_div (
  input  wire logic                     clk_i,
  input  wire logic                     start_i,
  input  wire logic                     step_i,
  input  wire logic [sga_pkg::DataW-1:0] dividend_i,
  input  wire logic [sga_pkg::DataW-1:0] divisor_i,
  output logic      [sga_pkg::DataW-1:0] quotient_o
);
  import sga_pkg::*;

  logic [DataW-1:0] rem_q, rem_d;
  logic [DataW-1:0] quo_q, quo_d;
  logic [DataW-1:0] dvs_q, dvs_d;
  logic             neg_q, neg_d;
  logic [DataW:0]   rem_sh;
  logic [DataW+1:0] diff;

  always_comb begin
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    neg_d  = neg_q;
    rem_sh = {rem_q, quo_q[DataW-1]};
    diff   = {1'b0, rem_sh} - {2'b00, dvs_q};
    if (start_i) begin
      neg_d = dividend_i[DataW-1];
      // magnitude; the most negative value maps onto itself as unsigned
      quo_d = dividend_i[DataW-1] ? (DataW'(0) - dividend_i) : dividend_i;
      rem_d = '0;
      dvs_d = divisor_i;
    end else if (step_i) begin
      if (!diff[DataW+1]) begin
        rem_d = diff[DataW-1:0];
        quo_d = {quo_q[DataW-2:0], 1'b1};
      end else begin
        rem_d = rem_sh[DataW-1:0];
        quo_d = {quo_q[DataW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
    neg_q <= neg_d;
  end

  assign quotient_o = neg_q ? (DataW'(0) - quo_q) : quo_q;

endmodule

`default_nettype wire

>>> design/sga_lane.sv
// one aggregator lane: column select, accumulator update and result divider
// uses sga_pkg and sga_div
`default_nettype none

module sga_lane (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire sga_pkg::lane_ctl_t        ctl_i,
  input  wire sga_pkg::func_e            func_i,
  input  wire logic [sga_pkg::SrcW-1:0]  src_i,
  input  wire sga_pkg::cols_t            cols_i,
  input  wire logic [sga_pkg::DataW-1:0] rows_i,
  output logic      [sga_pkg::DataW-1:0] result_o
);
  import sga_pkg::*;

  logic [DataW-1:0] acc_q, acc_d;
  logic [DataW-1:0] val;
  logic [DataW-1:0] quot;

  assign val = cols_i[src_i];

  always_comb begin
    acc_d = acc_q;
    if (ctl_i.apply) begin
      case (func_i)
        FN_SUM, FN_AVG: acc_d = ctl_i.first ? val : acc_q + val;
        FN_COUNT:       acc_d = ctl_i.first ? DataW'(1) : acc_q + DataW'(1);
        FN_MIN: begin
          if (ctl_i.first || ($signed(val) < $signed(acc_q))) acc_d = val;
        end
        FN_MAX: begin
          if (ctl_i.first || ($signed(val) > $signed(acc_q))) acc_d = val;
        end
        // undefined code: a new group starts from zero, otherwise hold
        default:        acc_d = ctl_i.first ? '0 : acc_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
    end else begin
      acc_q <= acc_d;
    end
  end

  sga_div u_div (
    .clk_i      (clk_i),
    .start_i    (ctl_i.start),
    .step_i     (ctl_i.step),
    .dividend_i (acc_q),
    .divisor_i  (rows_i),
    .quotient_o (quot)
  );

  assign result_o = (func_i == FN_AVG) ? quot : acc_q;

endmodule

`default_nettype wire

>>> design/sorted_group_by_aggregator.sv
// Streaming group-by over key-sorted rows. A row that neither changes the key nor carries
// final_row is absorbed without stalling the input. A row that closes a group holds the
// input stalled while each result goes out: the EMIT state loads the lane dividers, the
// DIV state runs the serial divider (one quotient bit per cycle, one divider per lane)
// and the PUSH state places the item in the output register once it is free; after a key
// change the APPLY state then folds in the row. Results leave through a single output
// register that is freed as soon as the downstream side takes it.
// uses sga_pkg and sga_lane
`default_nettype none

module sorted_group_by_aggregator #(
  parameter int unsigned NUM_AGG = 4
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire sga_pkg::in_t                  in_data_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output sga_pkg::out_t                      out_data_o,
  input  wire logic                          cfg_we_i,
  input  wire logic [sga_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  wire logic [sga_pkg::CfgDataW-1:0]  cfg_data_i
);
  import sga_pkg::*;

  localparam int unsigned Lanes = (NUM_AGG < NumCols) ? NUM_AGG : NumCols;

  state_e             state_q, state_d;
  logic               post_q, post_d;
  in_t                row_q, row_d;
  logic               group_open_q, group_open_d;
  logic [DataW-1:0]   open_key_q, open_key_d;
  logic [DataW-1:0]   rows_q, rows_d;
  logic [DivCntW-1:0] cnt_q, cnt_d;
  out_t               out_q, out_d;
  logic               out_valid_q, out_valid_d;
  func_e              func_q [NumCols];
  logic [SrcW-1:0]    src_q  [NumCols];

  lane_ctl_t          ctl;
  in_t                row_cur;
  cols_t              cols_cur;
  logic [DataW-1:0]   lane_res [NumCols];

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int j = 0; j < NumCols; j++) begin
        func_q[j] <= FN_SUM;
        src_q[j]  <= SrcW'(j);
      end
    end else if (cfg_we_i) begin
      if (cfg_idx_i < CfgSrcA) begin
        func_q[cfg_idx_i[SrcW-1:0]] <= func_e'(cfg_data_i);
      end else begin
        src_q[cfg_idx_i[SrcW-1:0]] <= cfg_data_i[SrcW-1:0];
      end
    end
  end

  assign row_cur  = (state_q == ST_APPLY) ? row_q : in_data_i;
  assign cols_cur = {row_cur.col_d, row_cur.col_c, row_cur.col_b, row_cur.col_a};

  always_comb begin
    state_d      = state_q;
    post_d       = post_q;
    row_d        = row_q;
    group_open_d = group_open_q;
    open_key_d   = open_key_q;
    rows_d       = rows_q;
    cnt_d        = cnt_q;
    out_d        = out_q;
    out_valid_d  = out_valid_q;
    ctl          = '0;
    ctl.first    = !group_open_q;
    in_stall_o   = (state_q != ST_IDLE);

    if (out_valid_q && !out_stall_i) out_valid_d = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          row_d = in_data_i;
          if (group_open_q && (in_data_i.row_key != open_key_q)) begin
            // close the open group before this row joins a new one
            post_d  = 1'b0;
            state_d = ST_EMIT;
          end else begin
            ctl.apply = 1'b1;
            if (in_data_i.final_row) begin
              post_d  = 1'b1;
              state_d = ST_EMIT;
            end
          end
        end
      end
      ST_APPLY: begin
        ctl.apply = 1'b1;
        if (row_q.final_row) begin
          post_d  = 1'b1;
          state_d = ST_EMIT;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_EMIT: begin
        ctl.start = 1'b1;
        cnt_d     = '0;
        state_d   = ST_DIV;
      end
      ST_DIV: begin
        ctl.step = 1'b1;
        cnt_d    = cnt_q + DivCntW'(1);
        if (cnt_q == DivCntW'(DivSteps - 1)) state_d = ST_PUSH;
      end
      ST_PUSH: begin
        if (!out_valid_q || !out_stall_i) begin
          out_d.group_key = open_key_q;
          out_d.agg_a     = lane_res[0];
          out_d.agg_b     = lane_res[1];
          out_d.agg_c     = lane_res[2];
          out_d.agg_d     = lane_res[3];
          out_d.run_end   = post_q | ~row_q.final_row;
          out_valid_d     = 1'b1;
          group_open_d    = 1'b0;
          state_d         = post_q ? ST_IDLE : ST_APPLY;
        end
      end
      default: state_d = ST_IDLE;
    endcase

    if (ctl.apply) begin
      group_open_d = 1'b1;
      if (ctl.first) begin
        open_key_d = row_cur.row_key;
        rows_d     = DataW'(1);
      end else if (rows_q != '1) begin
        rows_d = rows_q + DataW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      post_q       <= 1'b0;
      group_open_q <= 1'b0;
      open_key_q   <= '0;
      rows_q       <= '0;
      cnt_q        <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      post_q       <= post_d;
      group_open_q <= group_open_d;
      open_key_q   <= open_key_d;
      rows_q       <= rows_d;
      cnt_q        <= cnt_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    row_q <= row_d;
    out_q <= out_d;
  end

  for (genvar j = 0; j < NumCols; j++) begin : g_lane
    if (j < Lanes) begin : g_on
      sga_lane u_lane (
        .clk_i    (clk_i),
        .rst_ni   (rst_ni),
        .ctl_i    (ctl),
        .func_i   (func_q[j]),
        .src_i    (src_q[j]),
        .cols_i   (cols_cur),
        .rows_i   (rows_q),
        .result_o (lane_res[j])
      );
    end else begin : g_off
      assign lane_res[j] = '0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

>>> design/sga_checker.sv
// port-level checks for the sorted group-by aggregator, bound to the top level
// uses sga_pkg and sorted_group_by_aggregator_macros.svh
`default_nettype none

`include "sorted_group_by_aggregator_macros.svh"

module sga_checker (
  input wire logic          clk_i,
  input wire logic          rst_ni,
  input wire logic          in_valid_i,
  input wire logic          in_stall_o,
  input wire sga_pkg::in_t  in_data_i,
  input wire logic          out_valid_o,
  input wire logic          out_stall_i,
  input wire sga_pkg::out_t out_data_o
);
  import sga_pkg::*;

  // a waiting result holds until it is taken
  `SGA_ASSERT(a_out_hold, out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))

  // nothing leaves during reset, checked once reset has been sampled low at a clock edge
  `SGA_ASSERT_ALWAYS(a_rst_quiet, !rst_ni |=> (!rst_ni |-> !out_valid_o))

  // a final row always closes its group, so the block must turn busy
  `SGA_ASSERT(a_final_busy, in_valid_i && !in_stall_o && in_data_i.final_row |=> in_stall_o)

  // a first result of two means the row is still being worked on
  `SGA_ASSERT(a_mid_row_busy, out_valid_o && !out_data_o.run_end |-> in_stall_o)

endmodule

bind sorted_group_by_aggregator sga_checker u_sga_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);

`default_nettype wire
